/* design/mksp_pkg.sv */
// Shared types and constants of the multi-key short/long press scanner.
package mksp_pkg;

    localparam int KEY_LEVEL_BITS = 4;
    localparam int NOW_BITS       = 32;
    localparam int WINDOW_BITS    = 16;
    localparam int CODE_BITS      = 8;
    localparam int IN_TDATA_BITS  = 40;
    localparam int OUT_TDATA_BITS = 8;
    localparam int CFG_IDX_BITS   = 1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_CONFIRM = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LONG    = 1'b1;

    localparam logic [WINDOW_BITS-1:0] CONFIRM_RESET = 16'd10;
    localparam logic [WINDOW_BITS-1:0] LONG_RESET    = 16'd1000;

    localparam logic [CODE_BITS-1:0] NO_CODE         = 8'h00;
    localparam logic [CODE_BITS-1:0] SHORT_CODE_BASE = 8'h01;
    localparam logic [CODE_BITS-1:0] LONG_CODE_BASE  = 8'h81;

    // What one key would report on the current item if it is allowed to advance.
    typedef struct packed {
        logic short_rel;
        logic long_rel;
    } t_lane_rep;

endpackage

/* design/mksp_lane.sv */
// One key lane: press phase machine, press start time and elapsed-time compares.
module mksp_lane #(
    parameter int TIME_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_down,
    input  logic [TIME_BITS-1:0]               i_now,
    input  logic                               i_commit,
    input  logic [mksp_pkg::WINDOW_BITS-1:0]   i_confirm_ms,
    input  logic [mksp_pkg::WINDOW_BITS-1:0]   i_long_ms,
    output mksp_pkg::t_lane_rep                o_rep
);

    typedef enum logic [1:0] {
        PH_RELEASED = 2'd0,
        PH_CONFIRM  = 2'd1,
        PH_SHORT    = 2'd2,
        PH_LONG     = 2'd3
    } t_phase;

    t_phase               r_phase;
    t_phase               n_phase;
    logic [TIME_BITS-1:0] r_start;
    logic [TIME_BITS-1:0] w_elapsed;
    logic                 w_over_confirm;
    logic                 w_over_long;

    // Elapsed time wraps modulo the width of the time base.
    assign w_elapsed      = i_now - r_start;
    assign w_over_confirm = w_elapsed > TIME_BITS'(i_confirm_ms);
    assign w_over_long    = w_elapsed > TIME_BITS'(i_long_ms);

    always_comb begin
        n_phase         = r_phase;
        o_rep.short_rel = 1'b0;
        o_rep.long_rel  = 1'b0;
        unique case (r_phase)
            PH_RELEASED: begin
                if (i_down) n_phase = PH_CONFIRM;
            end
            PH_CONFIRM: begin
                if (!i_down) n_phase = PH_RELEASED;
                else if (w_over_confirm) n_phase = PH_SHORT;
            end
            PH_SHORT: begin
                if (!i_down) begin
                    n_phase         = PH_RELEASED;
                    o_rep.short_rel = 1'b1;
                end else if (w_over_long) begin
                    n_phase = PH_LONG;
                end
            end
            PH_LONG: begin
                if (!i_down) begin
                    n_phase        = PH_RELEASED;
                    o_rep.long_rel = 1'b1;
                end
            end
            default: n_phase = PH_RELEASED;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_RELEASED;
        end else if (i_commit) begin
            r_phase <= n_phase;
        end
    end

    // The start time is only read outside the released phase, after it was stored.
    always_ff @(posedge i_clk) begin
        if (i_commit && r_phase == PH_RELEASED && i_down) begin
            r_start <= i_now;
        end
    end

    a_hold_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_commit |=> $stable(r_phase))
        else $error("key phase moved on an item it was not allowed to see");

    a_report_releases: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_commit && (o_rep.short_rel || o_rep.long_rel) |=> r_phase == PH_RELEASED)
        else $error("reporting key did not return to released");

endmodule

/* design/mksp_merge.sv */
// Priority merge of the lane reports: first reporting key wins and blocks later keys.
module mksp_merge #(
    parameter int KEYS = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  mksp_pkg::t_lane_rep [KEYS-1:0]    i_rep,
    output logic [KEYS-1:0]                   o_commit,
    output logic [mksp_pkg::CODE_BITS-1:0]    o_code
);

    localparam int CB = mksp_pkg::CODE_BITS;

    logic            found;
    logic [KEYS-1:0] w_reporting;

    always_comb begin
        found    = 1'b0;
        o_code   = mksp_pkg::NO_CODE;
        o_commit = '0;
        for (int k = 0; k < KEYS; k++) begin
            w_reporting[k] = i_rep[k].short_rel | i_rep[k].long_rel;
            o_commit[k]    = i_accept & ~found;
            if (!found && i_rep[k].short_rel) begin
                o_code = mksp_pkg::SHORT_CODE_BASE + CB'(k);
                found  = 1'b1;
            end else if (!found && i_rep[k].long_rel) begin
                o_code = mksp_pkg::LONG_CODE_BASE + CB'(k);
                found  = 1'b1;
            end
        end
    end

    a_one_reporter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_reporting & o_commit))
        else $error("more than one key reported on one item");

    a_all_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && o_code == mksp_pkg::NO_CODE |-> &o_commit)
        else $error("a key was held back on an item without a report");

endmodule

/* design/multi_key_short_long_press_scanner_top.sv */
// Top level of the multi-key short/long press scanner: lanes, merge and output buffer.
//
// Usage:
//   Input channel (s_axis): one item per scan, tdata[3:0] = key levels (0 is pressed),
//   tdata[35:4] = current time in ms. Output channel (m_axis): one item per scan,
//   tdata[7:0] = key code (0 none, key+1 short press, key+0x81 long press).
//   Configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_idx (0 confirm
//   window, 1 long window); the user must write only while the block is idle.
//   The block does not enforce this. Throughput: one item per cycle while s_axis
//   tready is high; every key lane compares in the same cycle, a priority merge
//   picks the lowest reporting key, and lanes above that key hold for that item.
//   The output register is backed by a one-item skid register, so one more item
//   is accepted while a result waits; s_axis tready drops only when both are full.
//   Reset: all keys released, windows back to 10 ms and 1000 ms, both output
//   stages empty.
module multi_key_short_long_press_scanner_top #(
    parameter int KEYS      = 4,
    parameter int TIME_BITS = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // [3:0] key_levels, [35:4] now_ms, [39:36] zero
    input  logic [mksp_pkg::IN_TDATA_BITS-1:0]    i_s_axis_tdata,
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // [7:0] key_code
    output logic [mksp_pkg::OUT_TDATA_BITS-1:0]   o_m_axis_tdata,
    input  logic                                  i_cfg_we,
    input  logic [mksp_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [mksp_pkg::WINDOW_BITS-1:0]      i_cfg_wdata
);

    localparam int KLB = mksp_pkg::KEY_LEVEL_BITS;
    localparam int NB  = mksp_pkg::NOW_BITS;

    logic [mksp_pkg::WINDOW_BITS-1:0]   r_confirm_ms;
    logic [mksp_pkg::WINDOW_BITS-1:0]   r_long_ms;
    logic [KLB-1:0]                     w_levels;
    logic [NB-1:0]                      w_now_in;
    logic [TIME_BITS-1:0]               w_now;
    logic [KEYS-1:0]                    w_down;
    logic [KEYS-1:0]                    w_commit;
    mksp_pkg::t_lane_rep [KEYS-1:0]     w_rep;
    logic [mksp_pkg::CODE_BITS-1:0]     w_code;
    logic                               w_accept;
    logic                               w_take;

    logic                               r_out_valid;
    logic                               n_out_valid;
    logic [mksp_pkg::CODE_BITS-1:0]     r_out;
    logic [mksp_pkg::CODE_BITS-1:0]     n_out;
    logic                               r_skid_valid;
    logic                               n_skid_valid;
    logic [mksp_pkg::CODE_BITS-1:0]     r_skid;
    logic [mksp_pkg::CODE_BITS-1:0]     n_skid;

    assign w_levels = i_s_axis_tdata[KLB-1:0];
    assign w_now_in = i_s_axis_tdata[KLB+NB-1:KLB];
    assign w_now    = TIME_BITS'(w_now_in);

    assign o_s_axis_tready = ~r_skid_valid;
    assign w_accept        = i_s_axis_tvalid & o_s_axis_tready;
    assign w_take          = r_out_valid & i_m_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_confirm_ms <= mksp_pkg::CONFIRM_RESET;
            r_long_ms    <= mksp_pkg::LONG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mksp_pkg::CFG_CONFIRM: r_confirm_ms <= i_cfg_wdata;
                mksp_pkg::CFG_LONG:    r_long_ms    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Keys beyond the width of the level field always count as pressed.
    for (genvar k = 0; k < KEYS; k++) begin : g_lane
        if (k < KLB) begin : g_pin
            assign w_down[k] = ~w_levels[k];
        end else begin : g_nopin
            assign w_down[k] = 1'b1;
        end

        mksp_lane #(
            .TIME_BITS (TIME_BITS)
        ) u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_down       (w_down[k]),
            .i_now        (w_now),
            .i_commit     (w_commit[k]),
            .i_confirm_ms (r_confirm_ms),
            .i_long_ms    (r_long_ms),
            .o_rep        (w_rep[k])
        );
    end

    mksp_merge #(
        .KEYS (KEYS)
    ) u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_rep    (w_rep),
        .o_commit (w_commit),
        .o_code   (w_code)
    );

    // Output register with a skid register behind it; the skid item always drains first.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (!r_out_valid || w_take) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out        = r_skid;
                n_skid_valid = w_accept;
                n_skid       = w_code;
            end else begin
                n_out_valid = w_accept;
                n_out       = w_code;
            end
        end else if (w_accept) begin
            n_skid_valid = 1'b1;
            n_skid       = w_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds an item while the output register is empty");

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && !r_out_valid |=> r_out_valid && !r_skid_valid)
        else $error("accepted item did not reach the output register");

endmodule
